/* design/gpiopi_pkg.sv */
package gpiopi_pkg;

  // Word field widths
  localparam int CMD_W  = 2;
  localparam int OFS_W  = 12;
  localparam int DATA_W = 32;
  localparam int PAD_W  = 22;
  localparam int TYPE_W = 3;
  localparam int ENA_W  = 5;
  localparam int SEL_W  = 8;
  localparam int WORD_W = OFS_W - 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Register byte offsets
  localparam logic [OFS_W-1:0] OFF_OUT    = 12'h004;
  localparam logic [OFS_W-1:0] OFF_OUT_S  = 12'h008;
  localparam logic [OFS_W-1:0] OFF_OUT_C  = 12'h00c;
  localparam logic [OFS_W-1:0] OFF_EN     = 12'h020;
  localparam logic [OFS_W-1:0] OFF_EN_S   = 12'h024;
  localparam logic [OFS_W-1:0] OFF_EN_C   = 12'h028;
  localparam logic [OFS_W-1:0] OFF_IN     = 12'h03c;
  localparam logic [OFS_W-1:0] OFF_STAT   = 12'h044;
  localparam logic [OFS_W-1:0] OFF_STAT_C = 12'h04c;
  localparam logic [OFS_W-1:0] OFF_PIN0   = 12'h074;
  localparam logic [OFS_W-1:0] OFF_SEL0   = 12'h554;

  // Word addresses of the per-pin register banks
  localparam logic [WORD_W-1:0] PIN_WORD0 = OFF_PIN0[OFS_W-1:2];
  localparam logic [WORD_W-1:0] SEL_WORD0 = OFF_SEL0[OFS_W-1:2];

  // Per-pin config register layout
  localparam int TYPE_SHIFT = 7;
  localparam int ENA_SHIFT  = 13;
  localparam logic [ENA_W-1:0] ENA_MASK = 5'h1f;

  // Interrupt trigger types
  localparam logic [TYPE_W-1:0] TRIG_NONE    = 3'd0;
  localparam logic [TYPE_W-1:0] TRIG_RISE    = 3'd1;
  localparam logic [TYPE_W-1:0] TRIG_FALL    = 3'd2;
  localparam logic [TYPE_W-1:0] TRIG_ANY     = 3'd3;
  localparam logic [TYPE_W-1:0] TRIG_LOW     = 3'd4;
  localparam logic [TYPE_W-1:0] TRIG_HIGH    = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [OFS_W-1:0]  byte_offset;
    logic [DATA_W-1:0] write_data;
    logic [PAD_W-1:0]  pad_levels;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic [PAD_W-1:0]  pad_drive;
    logic [PAD_W-1:0]  pad_drive_enable;
  } out_item_t;

  // Decide whether one pin's sample fires its trigger type
  function automatic logic trig_hit(input logic [TYPE_W-1:0] ttype,
                                    input logic was, input logic is_now);
    logic hit;
    hit = 1'b0;
    unique case (ttype)
      TRIG_RISE: hit = !was && is_now;
      TRIG_FALL: hit = was && !is_now;
      TRIG_ANY:  hit = was != is_now;
      TRIG_LOW:  hit = !is_now;
      TRIG_HIGH: hit = is_now;
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

/* design/gpio_port_with_pin_interrupts.sv */
// GPIO port with per-pin interrupts, NUM_PINS pins behind a 32-bit register map.
// Input channel (in_valid/in_ready/in_data): one word per tick, read or write.
//   A tick samples pad_levels and updates the edge/level interrupt status; a
//   read or write addresses OUT, ENABLE (direct, set, clear), IN, STATUS,
//   STATUS_W1TC, the per-pin config and the output-select registers.
// Result channel (out_valid/out_ready/out_data): exactly one word per input
//   word, carrying read_data, irq and the pad drive/enable after that word.
// out_valid rises once the accepted input word has passed the input register
//   and the register file update and has been loaded into the result register.
// Throughput: one word per cycle while the receiver does not stall; the register
//   file update between the input and result registers sets this figure.
// Reset (rst_n low at a clock edge) clears all port registers, the interrupt
//   status, every pin config and both pipeline slots.
// When the receiver stalls, the result word is held, the input register
//   fills and in_ready drops; nothing is lost or repeated.
module gpio_port_with_pin_interrupts #(
  parameter int NUM_PINS = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gpiopi_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gpiopi_pkg::out_item_t out_data
);

  logic                  item_valid;
  gpiopi_pkg::in_item_t  item;
  logic                  space;
  logic                  step;
  gpiopi_pkg::out_item_t res;

  // Advance a word when it is present and the result slot can take it
  assign step = item_valid && space;

  gpiopi_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  gpiopi_core #(
    .NUM_PINS (NUM_PINS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  gpiopi_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/gpiopi_in_reg.sv */
module gpiopi_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gpiopi_pkg::in_item_t in_data,
  input  logic                 take,
  output logic                 item_valid,
  output gpiopi_pkg::in_item_t item
);

  logic                 valid_r;
  logic                 valid_nxt;
  gpiopi_pkg::in_item_t item_r;

  // Accept a new word whenever the slot is empty or drains this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload until the next accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* design/gpiopi_core.sv */
module gpiopi_core #(
  parameter int NUM_PINS = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  gpiopi_pkg::in_item_t  item,
  output gpiopi_pkg::out_item_t res
);

  localparam int PW    = NUM_PINS;
  localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  logic [PW-1:0] out_data_r,   out_data_nxt;
  logic [PW-1:0] out_enable_r, out_enable_nxt;
  logic [PW-1:0] sampled_r,    sampled_nxt;
  logic [PW-1:0] pending_r,    pending_nxt;

  logic [gpiopi_pkg::TYPE_W-1:0] trig_type_r [PW];
  logic [gpiopi_pkg::TYPE_W-1:0] trig_type_nxt [PW];
  logic [gpiopi_pkg::ENA_W-1:0]  trig_ena_r [PW];
  logic [gpiopi_pkg::ENA_W-1:0]  trig_ena_nxt [PW];
  logic [gpiopi_pkg::SEL_W-1:0]  sel_r [PW];
  logic [gpiopi_pkg::SEL_W-1:0]  sel_nxt [PW];

  logic                               is_tick, is_read, is_write;
  logic [gpiopi_pkg::OFS_W-1:0]       addr;
  logic [gpiopi_pkg::WORD_W-1:0]      word;
  logic [gpiopi_pkg::WORD_W-1:0]      pin_rel, sel_rel;
  logic                               pin_hit, sel_hit;
  logic [IDX_W-1:0]                   pin_idx, sel_idx;
  logic [gpiopi_pkg::DATA_W-1:0]      pads32;
  logic [PW-1:0]                      pads;
  logic [PW-1:0]                      wmask;
  logic [PW-1:0]                      hit_vec;
  logic [PW-1:0]                      cpu_en;
  logic [gpiopi_pkg::DATA_W-1:0]      rd;
  logic [gpiopi_pkg::DATA_W-1:0]      drive32, drive_en32;

  // Decode the command and the address
  assign is_tick  = item.cmd == gpiopi_pkg::CMD_TICK;
  assign is_read  = item.cmd == gpiopi_pkg::CMD_READ;
  assign is_write = item.cmd == gpiopi_pkg::CMD_WRITE;
  assign addr     = {item.byte_offset[gpiopi_pkg::OFS_W-1:2], 2'b00};
  assign word     = item.byte_offset[gpiopi_pkg::OFS_W-1:2];
  assign pin_rel  = word - gpiopi_pkg::PIN_WORD0;
  assign sel_rel  = word - gpiopi_pkg::SEL_WORD0;
  assign pin_hit  = (word >= gpiopi_pkg::PIN_WORD0) &&
                    (pin_rel < gpiopi_pkg::WORD_W'(NUM_PINS));
  assign sel_hit  = (word >= gpiopi_pkg::SEL_WORD0) &&
                    (sel_rel < gpiopi_pkg::WORD_W'(NUM_PINS));
  assign pin_idx  = pin_rel[IDX_W-1:0];
  assign sel_idx  = sel_rel[IDX_W-1:0];

  assign pads32 = gpiopi_pkg::DATA_W'(item.pad_levels);
  assign pads   = pads32[PW-1:0];
  assign wmask  = item.write_data[PW-1:0];

  // Match each pin's trigger against the new sample
  genvar n;
  generate
    for (n = 0; n < PW; n++) begin : g_pin
      assign hit_vec[n] = gpiopi_pkg::trig_hit(trig_type_r[n], sampled_r[n], pads[n]);

      // Update the per-pin config and output-select storage
      always_comb begin
        trig_type_nxt[n] = trig_type_r[n];
        trig_ena_nxt[n]  = trig_ena_r[n];
        sel_nxt[n]       = sel_r[n];
        if (is_write && pin_hit && pin_idx == IDX_W'(n)) begin
          trig_type_nxt[n] = item.write_data[gpiopi_pkg::TYPE_SHIFT +: gpiopi_pkg::TYPE_W];
          trig_ena_nxt[n]  = item.write_data[gpiopi_pkg::ENA_SHIFT +: gpiopi_pkg::ENA_W] &
                             gpiopi_pkg::ENA_MASK;
        end
        if (is_write && !pin_hit && sel_hit && sel_idx == IDX_W'(n)) begin
          sel_nxt[n] = item.write_data[gpiopi_pkg::SEL_W-1:0];
        end
      end

      assign cpu_en[n] = trig_ena_nxt[n][0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          trig_type_r[n] <= gpiopi_pkg::TRIG_NONE;
          trig_ena_r[n]  <= '0;
          sel_r[n]       <= '0;
        end else if (step) begin
          trig_type_r[n] <= trig_type_nxt[n];
          trig_ena_r[n]  <= trig_ena_nxt[n];
          sel_r[n]       <= sel_nxt[n];
        end
      end
    end
  endgenerate

  // Apply ticks and writes to the port-wide registers
  always_comb begin
    out_data_nxt   = out_data_r;
    out_enable_nxt = out_enable_r;
    sampled_nxt    = sampled_r;
    pending_nxt    = pending_r;
    if (is_tick) begin
      sampled_nxt = pads;
      pending_nxt = pending_r | hit_vec;
    end else if (is_write) begin
      priority if (addr == gpiopi_pkg::OFF_OUT) begin
        out_data_nxt = wmask;
      end else if (addr == gpiopi_pkg::OFF_OUT_S) begin
        out_data_nxt = out_data_r | wmask;
      end else if (addr == gpiopi_pkg::OFF_OUT_C) begin
        out_data_nxt = out_data_r & ~wmask;
      end else if (addr == gpiopi_pkg::OFF_EN) begin
        out_enable_nxt = wmask;
      end else if (addr == gpiopi_pkg::OFF_EN_S) begin
        out_enable_nxt = out_enable_r | wmask;
      end else if (addr == gpiopi_pkg::OFF_EN_C) begin
        out_enable_nxt = out_enable_r & ~wmask;
      end else if (addr == gpiopi_pkg::OFF_STAT_C) begin
        pending_nxt = pending_r & ~wmask;
      end else begin
        out_data_nxt = out_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_data_r   <= '0;
      out_enable_r <= '0;
      sampled_r    <= '0;
      pending_r    <= '0;
    end else if (step) begin
      out_data_r   <= out_data_nxt;
      out_enable_r <= out_enable_nxt;
      sampled_r    <= sampled_nxt;
      pending_r    <= pending_nxt;
    end
  end

  // Select the read word from the state before this access
  always_comb begin
    rd = '0;
    if (is_read) begin
      priority if (addr == gpiopi_pkg::OFF_OUT) begin
        rd = gpiopi_pkg::DATA_W'(out_data_r);
      end else if (addr == gpiopi_pkg::OFF_EN) begin
        rd = gpiopi_pkg::DATA_W'(out_enable_r);
      end else if (addr == gpiopi_pkg::OFF_IN) begin
        rd = gpiopi_pkg::DATA_W'(sampled_r);
      end else if (addr == gpiopi_pkg::OFF_STAT) begin
        rd = gpiopi_pkg::DATA_W'(pending_r);
      end else if (pin_hit) begin
        rd = (gpiopi_pkg::DATA_W'(trig_type_r[pin_idx]) << gpiopi_pkg::TYPE_SHIFT) |
             (gpiopi_pkg::DATA_W'(trig_ena_r[pin_idx]) << gpiopi_pkg::ENA_SHIFT);
      end else if (sel_hit) begin
        rd = gpiopi_pkg::DATA_W'(sel_r[sel_idx]);
      end else begin
        rd = '0;
      end
    end
  end

  // Report the port state after this word
  assign drive32    = gpiopi_pkg::DATA_W'(out_data_nxt);
  assign drive_en32 = gpiopi_pkg::DATA_W'(out_enable_nxt);

  assign res.read_data        = rd;
  assign res.irq              = |(pending_nxt & cpu_en);
  assign res.pad_drive        = drive32[gpiopi_pkg::PAD_W-1:0];
  assign res.pad_drive_enable = drive_en32[gpiopi_pkg::PAD_W-1:0];

endmodule

/* design/gpiopi_out_reg.sv */
module gpiopi_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  gpiopi_pkg::out_item_t res,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gpiopi_pkg::out_item_t out_data
);

  logic                  valid_r;
  logic                  valid_nxt;
  gpiopi_pkg::out_item_t data_r;

  // Take a new result when empty or when the held word leaves now
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result word while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
